FILE: hdl/bblur_pkg.sv
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared types and constants of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned PIX_W    = 3 * CH_W;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFGW_W   = 11;
  localparam int unsigned CFGH_W   = 16;
  localparam int unsigned ROW_W    = CFGH_W + 1;
  localparam int unsigned SUM_W    = 12;
  localparam int unsigned NUM_W    = 13;
  localparam int unsigned RECIP_W  = 14;
  localparam int unsigned PROD_W   = NUM_W + RECIP_W;
  localparam int unsigned RECIP_SH = 16;
  localparam int unsigned MQ_DEPTH = 4;
  localparam int unsigned OQ_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [CFGW_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFGH_W-1:0] HEIGHT_RESET = 16'd480;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // which taps of the window fall outside the image
  typedef struct packed {
    logic top_x;
    logic bot_x;
    logic left_x;
    logic right_x;
    logic frame_end;
  } flags_t;

  // one column of the window plus what the back end needs to know about it
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] pix;
    logic             out_v;
    flags_t           flags;
  } col_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } res_t;

  // number of pixels averaged: 4, 6 or 9
  function automatic logic [3:0] div_count(input logic rows3, input logic cols3);
    logic [3:0] d;
    case ({rows3, cols3}) inside
      2'b00:        d = 4'd4;
      2'b01, 2'b10: d = 4'd6;
      default:      d = 4'd9;
    endcase
    return d;
  endfunction

  // ceil(2^16 / (2*d)); exact for every numerator below 2^13
  function automatic logic [RECIP_W-1:0] div_recip(input logic rows3, input logic cols3);
    logic [RECIP_W-1:0] m;
    case ({rows3, cols3}) inside
      2'b00:        m = 14'd8192;
      2'b01, 2'b10: m = 14'd5462;
      default:      m = 14'd3641;
    endcase
    return m;
  endfunction

endpackage

FILE: hdl/bblur_fifo.sv
// ----------------------------------------------------------------------------
// bblur_fifo
// Small register queue; head entry shown while not empty.
// ----------------------------------------------------------------------------
module bblur_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/bblur_front.sv
// ----------------------------------------------------------------------------
// bblur_front
// Takes pixel and drain items, tracks frame position, runs the line memory
// and tags each column with its border and frame-end flags.
// ----------------------------------------------------------------------------
module bblur_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bblur_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                push_i,
  input  logic                                mode_i,
  input  logic [bblur_pkg::CH_W-1:0]          red_i,
  input  logic [bblur_pkg::CH_W-1:0]          green_i,
  input  logic [bblur_pkg::CH_W-1:0]          blue_i,
  output logic                                full_o,
  output logic                                mq_push_o,
  output bblur_pkg::col_item_t                mq_item_o,
  input  logic                                mq_full_i
);
  import bblur_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = (AW + 1 > CFGW_W) ? AW + 1 : CFGW_W;

  logic [CFGW_W-1:0] width_q;
  logic [CFGH_W-1:0] height_q;
  logic [EW-1:0]     w_raw, w_eff, wm1;
  logic [CFGH_W-1:0] h_eff, hm1;

  logic [AW-1:0]     col_q, ocol_q;
  logic [ROW_W-1:0]  row_q;
  logic [CFGH_W-1:0] orow_q;

  logic [EW-1:0]     col_inc, ocol_inc;
  logic              col_wrap, ocol_wrap, out_now, accept;
  flags_t            fl;
  logic [PIX_W-1:0]  pix;

  // line memory entry: {older row, newer row}
  logic [2*PIX_W-1:0] lb_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  logic              s1_q;
  logic [AW-1:0]     s1_ci_q;
  logic [PIX_W-1:0]  s1_pix_q;
  logic              s1_out_q;
  flags_t            s1_flags_q;

  assign w_raw = EW'(width_q);
  assign w_eff = (w_raw < EW'(2)) ? EW'(2) :
                 (w_raw > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_raw;
  assign wm1   = w_eff - EW'(1);
  assign h_eff = (height_q < CFGH_W'(2)) ? CFGH_W'(2) : height_q;
  assign hm1   = h_eff - CFGH_W'(1);

  assign mq_push_o = s1_q && !mq_full_i;
  assign full_o    = s1_q && mq_full_i;
  assign accept    = push_i && !full_o;

  always_comb begin
    col_inc      = EW'(col_q) + EW'(1);
    col_wrap     = (col_inc >= w_eff);
    ocol_inc     = EW'(ocol_q) + EW'(1);
    ocol_wrap    = (ocol_inc >= w_eff);
    out_now      = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
    fl.top_x     = (orow_q == '0);
    fl.bot_x     = (orow_q >= hm1);
    fl.left_x    = (ocol_q == '0);
    fl.right_x   = (EW'(ocol_q) >= wm1);
    fl.frame_end = out_now && fl.bot_x && fl.right_x;
    // drain items and anything past the last row enter as black
    if (mode_i == MODE_PIXEL && row_q < ROW_W'(h_eff)) begin
      pix = {red_i, green_i, blue_i};
    end else begin
      pix = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[CFGW_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[CFGH_W-1:0];
      endcase
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (accept) begin
      if (fl.frame_end) begin
        col_q  <= '0;
        row_q  <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end else begin
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_inc[AW-1:0];
        end
        if (out_now) begin
          if (ocol_wrap) begin
            ocol_q <= '0;
            orow_q <= orow_q + CFGH_W'(1);
          end else begin
            ocol_q <= ocol_inc[AW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else if (accept) begin
      s1_q <= 1'b1;
    end else if (mq_push_o) begin
      s1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ci_q    <= col_q;
      s1_pix_q   <= pix;
      s1_out_q   <= out_now;
      s1_flags_q <= fl;
    end
  end

  // consecutive items share a column only across a restart; the stale read
  // there lands in rows above the image, which are never summed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= lb_mem[col_q];
    end
    if (mq_push_o) begin
      lb_mem[s1_ci_q] <= {rd_q[PIX_W-1:0], s1_pix_q};
    end
  end

  always_comb begin
    mq_item_o.top   = rd_q[2*PIX_W-1:PIX_W];
    mq_item_o.mid   = rd_q[PIX_W-1:0];
    mq_item_o.pix   = s1_pix_q;
    mq_item_o.out_v = s1_out_q;
    mq_item_o.flags = s1_flags_q;
  end

endmodule

FILE: hdl/bblur_back.sv
// ----------------------------------------------------------------------------
// bblur_back
// 3x3 window, masked channel sums and rounded mean by reciprocal multiply.
// ----------------------------------------------------------------------------
module bblur_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 mq_empty_i,
  input  bblur_pkg::col_item_t mq_item_i,
  output logic                 mq_pop_o,
  output logic                 oq_push_o,
  output bblur_pkg::res_t      oq_item_o,
  input  logic                 oq_full_i
);
  import bblur_pkg::*;

  logic [PIX_W-1:0]   win_q [3][3];
  logic               b1_q, b2_q;
  flags_t             b1_flags_q;
  logic               b1_ready, b2_ready;

  logic [2:0]         row_use, col_use;
  logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
  logic [3:0]         d;
  logic [RECIP_W-1:0] m;

  logic [NUM_W-1:0]   num_q [3];
  logic [RECIP_W-1:0] m_q;
  logic               fe_q;
  logic [PROD_W-1:0]  prod [3];

  assign b2_ready  = !b2_q || !oq_full_i;
  assign oq_push_o = b2_q && !oq_full_i;
  assign b1_ready  = !b1_q || b2_ready;
  assign mq_pop_o  = !mq_empty_i && b1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_q <= 1'b0;
      b2_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      if (mq_pop_o) begin
        b1_q <= mq_item_i.out_v;
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= mq_item_i.top;
        win_q[1][2] <= mq_item_i.mid;
        win_q[2][2] <= mq_item_i.pix;
      end else if (b2_ready) begin
        b1_q <= 1'b0;
      end
      if (b1_q && b2_ready) begin
        b2_q <= 1'b1;
      end else if (oq_push_o) begin
        b2_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mq_pop_o) begin
      b1_flags_q <= mq_item_i.flags;
    end
  end

  // taps outside the image are skipped, never read as data
  always_comb begin
    row_use = {!b1_flags_q.bot_x, 1'b1, !b1_flags_q.top_x};
    col_use = {!b1_flags_q.right_x, 1'b1, !b1_flags_q.left_x};
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_use[i] && col_use[j]) begin
          sum_r = sum_r + SUM_W'(win_q[i][j][3*CH_W-1:2*CH_W]);
          sum_g = sum_g + SUM_W'(win_q[i][j][2*CH_W-1:CH_W]);
          sum_b = sum_b + SUM_W'(win_q[i][j][CH_W-1:0]);
        end
      end
    end
    d = div_count(row_use[0] && row_use[2], col_use[0] && col_use[2]);
    m = div_recip(row_use[0] && row_use[2], col_use[0] && col_use[2]);
  end

  // numerator 2*sum + d, divided by 2*d below
  always_ff @(posedge clk_i) begin
    if (b1_q && b2_ready) begin
      num_q[0] <= {sum_r, 1'b0} + NUM_W'(d);
      num_q[1] <= {sum_g, 1'b0} + NUM_W'(d);
      num_q[2] <= {sum_b, 1'b0} + NUM_W'(d);
      m_q      <= m;
      fe_q     <= b1_flags_q.frame_end;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PROD_W'(num_q[c]) * PROD_W'(m_q);
    end
    oq_item_o.red       = prod[0][RECIP_SH+CH_W-1:RECIP_SH];
    oq_item_o.green     = prod[1][RECIP_SH+CH_W-1:RECIP_SH];
    oq_item_o.blue      = prod[2][RECIP_SH+CH_W-1:RECIP_SH];
    oq_item_o.frame_end = fe_q;
  end

endmodule

FILE: hdl/box_blur_3x3_rgb.sv
// Path: a result passes the front stage, middle queue, window stage, numerator
// stage and output queue; results lag inputs by width+1 items.
// Throughput: one item per clock while full stays low, set by the line memory (one
// read at accept, one write as the item enters the middle queue) and the
// single-entry window stage. Reset: counters and queues clear, width 640, height
// 480; line memory keeps no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur of raster-order RGB pixels with border-aware means.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic                             mode_i,
  input  logic [bblur_pkg::CH_W-1:0]       red_in_i,
  input  logic [bblur_pkg::CH_W-1:0]       green_in_i,
  input  logic [bblur_pkg::CH_W-1:0]       blue_in_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [bblur_pkg::CH_W-1:0]       red_out_o,
  output logic [bblur_pkg::CH_W-1:0]       green_out_o,
  output logic [bblur_pkg::CH_W-1:0]       blue_out_o,
  output logic                             frame_end_o
);
  import bblur_pkg::*;

  logic      mq_push, mq_pop, mq_empty, mq_full;
  col_item_t mq_in, mq_out;
  logic      oq_push, oq_full;
  res_t      oq_in, oq_out;

  assign cfg_ready_o = 1'b1;

  bblur_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .mode_i      (mode_i),
    .red_i       (red_in_i),
    .green_i     (green_in_i),
    .blue_i      (blue_in_i),
    .full_o      (full),
    .mq_push_o   (mq_push),
    .mq_item_o   (mq_in),
    .mq_full_i   (mq_full)
  );

  bblur_fifo #(
    .DATA_W ($bits(col_item_t)),
    .DEPTH  (MQ_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mq_push),
    .data_i  (mq_in),
    .pop_i   (mq_pop),
    .data_o  (mq_out),
    .empty_o (mq_empty),
    .full_o  (mq_full)
  );

  bblur_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mq_empty_i (mq_empty),
    .mq_item_i  (mq_out),
    .mq_pop_o   (mq_pop),
    .oq_push_o  (oq_push),
    .oq_item_o  (oq_in),
    .oq_full_i  (oq_full)
  );

  bblur_fifo #(
    .DATA_W ($bits(res_t)),
    .DEPTH  (OQ_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (oq_push),
    .data_i  (oq_in),
    .pop_i   (pop),
    .data_o  (oq_out),
    .empty_o (empty),
    .full_o  (oq_full)
  );

  assign red_out_o   = oq_out.red;
  assign green_out_o = oq_out.green;
  assign blue_out_o  = oq_out.blue;
  assign frame_end_o = oq_out.frame_end;

endmodule
